// ===== design/wsp_pkg.sv =====
// Shared constants and types for the window sum peak counter.
package wsp_pkg;

  // Delay line depth and sample width.
  localparam int WINDOW_MAX  = 4096;
  localparam int SAMPLE_BITS = 16;

  // Fixed port widths.
  localparam int SAMPLE_PORT_W = 16;
  localparam int CFG_LEN_W     = 13;
  localparam int BEST_SUM_W    = 28;
  localparam int BEST_COUNT_W  = 24;

  // Derived widths.
  localparam int SAMPLE_W = (SAMPLE_BITS < SAMPLE_PORT_W) ? SAMPLE_BITS : SAMPLE_PORT_W;
  localparam int SLOT_W   = $clog2(WINDOW_MAX);
  localparam int LEN_W    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W    = SAMPLE_W + LEN_W;
  localparam int DELTA_W  = SAMPLE_W + 1;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // APB register map.
  localparam int PADDR_W = 3;
  localparam logic REG_WINDOW_LEN = 1'b0;

  // One classified transaction on its way to the back part.
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;  // new sample minus the sample leaving
    logic                      first;  // window just became full
    logic                      seen;   // window full after this sample
    logic                      last;   // closes the series
  } wsp_entry_t;

endpackage

// ===== design/wsp_ram.sv =====
// Generic single-write, single-read RAM with registered read-first output.
module wsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read in one process: a read of the slot being written returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/wsp_queue.sv =====
// Short FIFO of classified transactions between the front and back parts.
module wsp_queue
  import wsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsp_entry_t        push_data_i,
  input  logic              pop_i,
  output wsp_entry_t        pop_data_o,
  output logic              empty_o,
  output logic [QCNT_W-1:0] count_o
);

  wsp_entry_t        slots_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  // Advance pointers and count.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store payload.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = slots_q[rptr_q];
  assign empty_o    = (cnt_q == '0);
  assign count_o    = cnt_q;

endmodule

// ===== design/wsp_front.sv =====
// Front part: accepts samples, runs the delay line and classifies each transaction.
module wsp_front
  import wsp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic [LEN_W-1:0]         len_i,
  input  logic [SAMPLE_PORT_W-1:0] sample_i,
  input  logic                     last_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [QCNT_W-1:0]        q_count_i,
  output logic                     push_o,
  output wsp_entry_t               push_data_o
);

  logic                accept;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [LEN_W-1:0]    fill_q, fill_d;
  logic [LEN_W:0]      slot_ext, len_ext;
  logic [SLOT_W-1:0]   old_slot;
  logic                full_now, first_now;
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0] old_data;

  // Stage between the RAM read and the queue push.
  logic                s1_valid_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic                s1_sub_q, s1_first_q, s1_seen_q, s1_last_q;

  // Take a transaction only when the queue has room for everything in flight.
  assign in_ready_o = ({1'b0, q_count_i} + {{QCNT_W{1'b0}}, s1_valid_q}) < (QCNT_W + 1)'(QDEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign smp        = sample_i[SAMPLE_W-1:0];

  // Classify against the current fill level.
  assign full_now  = (fill_q >= len_i);
  assign first_now = !full_now && ((fill_q + 1'b1) == len_i);

  // Slot of the sample leaving the window.
  assign slot_ext = (LEN_W + 1)'(slot_q);
  assign len_ext  = {1'b0, len_i};
  assign old_slot = (slot_ext >= len_ext) ? SLOT_W'(slot_ext - len_ext)
                                          : SLOT_W'(slot_ext + (LEN_W + 1)'(WINDOW_MAX) - len_ext);

  wsp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_q),
    .wdata_i (smp),
    .raddr_i (old_slot),
    .rdata_o (old_data)
  );

  // Advance write slot and fill level; drop them on clear or at the end of a series.
  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    if (clear_i) begin
      slot_d = '0;
      fill_d = '0;
    end else if (accept) begin
      if (last_i) begin
        slot_d = '0;
        fill_d = '0;
      end else begin
        slot_d = (slot_q == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_q + 1'b1;
        fill_d = full_now ? fill_q : fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      slot_q     <= slot_d;
      fill_q     <= fill_d;
      s1_valid_q <= accept;
    end
  end

  // Hold the transaction while the RAM read completes.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= smp;
      s1_sub_q    <= full_now;
      s1_first_q  <= first_now;
      s1_seen_q   <= full_now || first_now;
      s1_last_q   <= last_i;
    end
  end

  // Form the sum change and push.
  assign push_o            = s1_valid_q;
  assign push_data_o.delta = $signed({1'b0, s1_sample_q})
                           - $signed({1'b0, (s1_sub_q ? old_data : {SAMPLE_W{1'b0}})});
  assign push_data_o.first = s1_first_q;
  assign push_data_o.seen  = s1_seen_q;
  assign push_data_o.last  = s1_last_q;

endmodule

// ===== design/wsp_back.sv =====
// Back part: running sum, peak tracking and the result register.
module wsp_back
  import wsp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic                    q_empty_i,
  input  wsp_entry_t              q_data_i,
  output logic                    pop_o,
  output logic [BEST_SUM_W-1:0]   best_sum_o,
  output logic [BEST_COUNT_W-1:0] best_count_o,
  output logic                    window_seen_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i
);

  localparam int EXT_W = (SUM_W > BEST_SUM_W) ? SUM_W : BEST_SUM_W;

  logic [SUM_W-1:0]        sum_q, sum_d, sum_n;
  logic [SUM_W-1:0]        peak_q, peak_d;
  logic [BEST_COUNT_W-1:0] hits_q, hits_d;
  logic [EXT_W-1:0]        peak_ext;
  logic                    out_valid_q, out_valid_d;
  logic [BEST_SUM_W-1:0]   best_sum_q, best_sum_d;
  logic [BEST_COUNT_W-1:0] best_count_q, best_count_d;
  logic                    seen_q, seen_d;

  // Pop when the result register is free or being drained.
  assign pop_o = !q_empty_i && (!out_valid_q || out_ready_i);

  assign sum_n = sum_q + {{(SUM_W - DELTA_W){q_data_i.delta[DELTA_W-1]}}, q_data_i.delta};

  // Update sum and peak, then form the result.
  always_comb begin
    sum_d        = sum_q;
    peak_d       = peak_q;
    hits_d       = hits_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    best_sum_d   = best_sum_q;
    best_count_d = best_count_q;
    seen_d       = seen_q;
    peak_ext     = '0;
    if (clear_i) begin
      sum_d  = '0;
      peak_d = '0;
      hits_d = '0;
    end else if (pop_o) begin
      sum_d = sum_n;
      if (q_data_i.seen) begin
        if (q_data_i.first || (sum_n > peak_q)) begin
          peak_d = sum_n;
          hits_d = BEST_COUNT_W'(1);
        end else if (sum_n == peak_q) begin
          hits_d = (hits_q == {BEST_COUNT_W{1'b1}}) ? hits_q : hits_q + 1'b1;
        end
      end
      peak_ext     = EXT_W'(peak_d);
      out_valid_d  = 1'b1;
      seen_d       = q_data_i.seen;
      best_sum_d   = '0;
      best_count_d = '0;
      if (q_data_i.seen) begin
        best_sum_d   = (peak_ext > EXT_W'({BEST_SUM_W{1'b1}})) ? {BEST_SUM_W{1'b1}}
                                                               : BEST_SUM_W'(peak_ext);
        best_count_d = hits_d;
      end
      if (q_data_i.last) begin
        sum_d  = '0;
        peak_d = '0;
        hits_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      peak_q      <= '0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      peak_q      <= peak_d;
      hits_q      <= hits_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    best_sum_q   <= best_sum_d;
    best_count_q <= best_count_d;
    seen_q       <= seen_d;
  end

  assign out_valid_o   = out_valid_q;
  assign best_sum_o    = best_sum_q;
  assign best_count_o  = best_count_q;
  assign window_seen_o = seen_q;

endmodule

// ===== design/window_sum_peak_counter.sv =====
// Top level of the sliding-window peak sum counter with its APB register.
// Takes one sample per cycle while in_ready_o is high and returns one result per
// sample: the largest full-window sum of the series so far, how many window
// positions reached it (saturating), and whether a full window has arrived. A
// sample with last set closes the series. Throughput is one transaction per clock
// while out_ready_i stays high, set by the delay-line RAM, which takes one write
// and one read each cycle; a result is offered after the history read with its
// stage register, the queue and then the result register. Writing window_len
// (address 0) starts a new series; 0 acts as 1 and values above 4096 act as 4096.
// Write it only while the block is idle.
module window_sum_peak_counter
  import wsp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [SAMPLE_PORT_W-1:0] sample_i,
  input  logic                     last_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic [BEST_SUM_W-1:0]    best_sum_o,
  output logic [BEST_COUNT_W-1:0]  best_count_o,
  output logic                     window_seen_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [CFG_LEN_W-1:0] win_len_q, win_len_d;
  logic [LEN_W-1:0]     eff_len;
  logic                 cfg_wr;
  logic                 push, pop, q_empty;
  wsp_entry_t           push_data, pop_data;
  logic [QCNT_W-1:0]    q_count;

  // Decode register write.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_LEN);

  always_comb begin
    win_len_d = win_len_q;
    if (cfg_wr) begin
      win_len_d = pwdata[CFG_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= CFG_LEN_W'(1);
    end else begin
      win_len_q <= win_len_d;
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW_LEN) ? 32'(win_len_q) : '0;

  // Clamp window length to the supported range.
  always_comb begin
    if (win_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(win_len_q) > 32'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = LEN_W'(win_len_q);
    end
  end

  wsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_wr),
    .len_i       (eff_len),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  wsp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  wsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (cfg_wr),
    .q_empty_i     (q_empty),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .best_sum_o    (best_sum_o),
    .best_count_o  (best_count_o),
    .window_seen_o (window_seen_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i)
  );

endmodule
